// ===== src/rqms_pkg.sv =====
// ----------------------------------------------------------------------------
// Ready queue package
// Command, status and state codes, the cell operation and the entry record
// shared by the ready queue cells and the top level.
// ----------------------------------------------------------------------------
package rqms_pkg;

    typedef enum logic [2:0] {
        CMD_ENQ        = 3'd0,
        CMD_POP        = 3'd1,
        CMD_PEEK_FRONT = 3'd2,
        CMD_REM_SHORT  = 3'd3,
        CMD_REM_PRI    = 3'd4,
        CMD_PEEK_SHORT = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_ROTATE,
        OP_COMPACT
    } t_cell_op;

    typedef struct packed {
        logic [15:0] pid;
        logic [15:0] rem;
        logic [7:0]  pri;
    } t_entry;

    localparam t_entry ENTRY_ZERO = '{pid: 16'd0, rem: 16'd0, pri: 8'd0};

endpackage

// ===== src/rqms_cell.sv =====
// ----------------------------------------------------------------------------
// Ready queue cell
// Holds one queue entry. Loads a new entry at the tail position, takes its
// upper neighbor's entry on a ring rotation, or closes the gap left by a
// removed entry at or below its own position.
// ----------------------------------------------------------------------------
module rqms_cell import rqms_pkg::*; #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  logic          i_clk,
    input  t_cell_op      i_op,
    input  logic [IW-1:0] i_sel,
    input  logic [CW-1:0] i_count,
    input  t_entry        i_load,
    input  t_entry        i_next,
    output t_entry        o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            OP_LOAD: begin
                if (i_count == CW'(IDX)) begin
                    n_entry = i_load;
                end
            end
            OP_ROTATE: begin
                n_entry = i_next;
            end
            OP_COMPACT: begin
                if (IW'(IDX) >= i_sel) begin
                    n_entry = i_next;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== src/ready_queue_min_select.sv =====
// ----------------------------------------------------------------------------
// Ready queue with minimum select
// Enqueue, pop, peek-oldest, unused codes and any command on an empty queue go
// from idle straight to the finish state; shortest and best-priority commands
// on a non-empty queue first pass the scan state, where the entry ring rotates
// one cell per cycle past the head compare. The result is registered in the
// finish state once the result side is free; no new request is taken until idle.
// Reset: entry count and control clear; entry contents stay undefined.
// ----------------------------------------------------------------------------
module ready_queue_min_select import rqms_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_pid_in,
    input  logic [15:0] i_remaining_in,
    input  logic [7:0]  i_priority_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_pid_out,
    output logic [15:0] o_remaining_out,
    output logic [7:0]  o_priority_out,
    output logic [4:0]  o_occupancy
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state        r_state,     n_state;
    t_cmd          r_cmd,       n_cmd;
    t_entry        r_req,       n_req;
    logic [IW-1:0] r_k,         n_k;
    t_entry        r_best,      n_best;
    logic [IW-1:0] r_best_idx,  n_best_idx;
    logic [15:0]   r_best_key,  n_best_key;
    logic [CW-1:0] r_count,     n_count;
    logic          r_out_valid, n_out_valid;
    t_status       r_status,    n_status;
    t_entry        r_res,       n_res;
    logic [4:0]    r_occ,       n_occ;

    t_cell_op      w_op;
    logic [IW-1:0] w_sel;
    logic [15:0]   w_key;
    logic          w_in_acc;
    logic          w_out_free;
    t_entry        w_entry [QUEUE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            rqms_cell #(
                .IDX (gi),
                .IW  (IW),
                .CW  (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_sel   (w_sel),
                .i_count (r_count),
                .i_load  (r_req),
                .i_next  (w_entry[(gi + 1) % QUEUE_DEPTH]),
                .o_entry (w_entry[gi])
            );
        end
    endgenerate

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_key      = (r_cmd == CMD_REM_PRI) ? {8'd0, w_entry[0].pri} : w_entry[0].rem;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_req       = r_req;
        n_k         = r_k;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_best_key  = r_best_key;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_res       = r_res;
        n_occ       = r_occ;
        w_op        = OP_HOLD;
        w_sel       = '0;
        o_in_stall  = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_req   = '{pid: i_pid_in, rem: i_remaining_in, pri: i_priority_in};
                    n_k     = '0;
                    n_state = S_FIN;
                    if ((i_cmd == CMD_REM_SHORT || i_cmd == CMD_REM_PRI ||
                         i_cmd == CMD_PEEK_SHORT) && r_count != '0) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_op = OP_ROTATE;
                if (CW'(r_k) < r_count && (r_k == '0 || w_key < r_best_key)) begin
                    n_best     = w_entry[0];
                    n_best_idx = r_k;
                    n_best_key = w_key;
                end
                n_k = r_k + 1'b1;
                if (r_k == IW'(QUEUE_DEPTH - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_res       = ENTRY_ZERO;
                    n_state     = S_IDLE;
                    case (r_cmd)
                        CMD_ENQ: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_op    = OP_LOAD;
                                n_res   = r_req;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_POP, CMD_PEEK_FRONT, CMD_REM_SHORT, CMD_REM_PRI,
                        CMD_PEEK_SHORT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_res = (r_cmd inside {CMD_POP, CMD_PEEK_FRONT}) ?
                                        w_entry[0] : r_best;
                                if (r_cmd inside {CMD_POP, CMD_REM_SHORT, CMD_REM_PRI}) begin
                                    w_op    = OP_COMPACT;
                                    w_sel   = (r_cmd == CMD_POP) ? '0 : r_best_idx;
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                    n_occ = 5'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_req      <= n_req;
        r_k        <= n_k;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_key <= n_best_key;
        r_status   <= n_status;
        r_res      <= n_res;
        r_occ      <= n_occ;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_pid_out       = r_res.pid;
    assign o_remaining_out = r_res.rem;
    assign o_priority_out  = r_res.pri;
    assign o_occupancy     = r_occ;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("request taken without leaving idle");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (r_count == CW'(QUEUE_DEPTH)))
        else $error("full status with free entries");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("entry count changed during scan");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue with minimum select: testbench
// Drives queue commands through the request channel and checks each result
// against a behavioral copy of the queue: arrival order, oldest-wins ties on
// shortest and best-priority selection, the full and empty cases, and the
// unused command codes. Both channels idle at random and the result side holds
// off long enough to back the queue up into the request side.
// ----------------------------------------------------------------------------
module testbench;
    import rqms_pkg::*;

    localparam int          QUEUE_DEPTH    = 16;
    localparam int          DRAIN_CYCLES   = QUEUE_DEPTH + 4;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          LONG_HOLD      = 150;
    localparam logic [2:0]  CMD_SPARE_LO   = 3'd6;
    localparam logic [2:0]  CMD_SPARE_HI   = 3'd7;

    typedef struct packed {
        t_status     status;
        t_entry      entry;
        logic [4:0]  occupancy;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_cmd;
    logic [15:0] i_pid_in;
    logic [15:0] i_remaining_in;
    logic [7:0]  i_priority_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [15:0] o_pid_out;
    logic [15:0] o_remaining_out;
    logic [7:0]  o_priority_out;
    logic [4:0]  o_occupancy;

    t_entry   ready_list[$];
    t_outcome expected_outcomes[$];

    bit idling_on;
    int hold_request;
    int mismatch_count;
    int requests_sent;
    int results_checked;
    int full_drops;
    int empty_hits;
    int peak_occupancy;
    int quiet_cycles;

    ready_queue_min_select #(.QUEUE_DEPTH(QUEUE_DEPTH)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_pid_in       (i_pid_in),
        .i_remaining_in (i_remaining_in),
        .i_priority_in  (i_priority_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_pid_out      (o_pid_out),
        .o_remaining_out(o_remaining_out),
        .o_priority_out (o_priority_out),
        .o_occupancy    (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_outcome schedule_command(logic [2:0] cmd, t_entry item);
        t_outcome r;
        int       sel;
        r = '{status: ST_OK, entry: ENTRY_ZERO, occupancy: 5'd0};
        sel = -1;
        case (cmd)
            CMD_ENQ: begin
                if (ready_list.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                    full_drops++;
                end else begin
                    ready_list.push_back(item);
                    sel = ready_list.size() - 1;
                end
            end
            CMD_POP, CMD_PEEK_FRONT, CMD_REM_SHORT, CMD_REM_PRI, CMD_PEEK_SHORT: begin
                if (ready_list.size() == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    sel = 0;
                    for (int i = 1; i < ready_list.size(); i++) begin
                        if ((cmd == CMD_REM_SHORT || cmd == CMD_PEEK_SHORT) &&
                            ready_list[i].rem < ready_list[sel].rem)
                            sel = i;
                        if (cmd == CMD_REM_PRI && ready_list[i].pri < ready_list[sel].pri)
                            sel = i;
                    end
                end
            end
            default: ;
        endcase
        if (sel >= 0) begin
            r.entry = ready_list[sel];
            if (cmd == CMD_POP || cmd == CMD_REM_SHORT || cmd == CMD_REM_PRI)
                ready_list.delete(sel);
        end
        r.occupancy = 5'(ready_list.size());
        if (ready_list.size() > peak_occupancy)
            peak_occupancy = ready_list.size();
        return r;
    endfunction

    task automatic send_request(input logic [2:0] cmd, input logic [15:0] pid,
                                input logic [15:0] rem, input logic [7:0] pri);
        t_entry item;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_pid_in       <= pid;
        i_remaining_in <= rem;
        i_priority_in  <= pri;
        do @(posedge i_clk); while (o_in_stall);
        item = '{pid: pid, rem: rem, pri: pri};
        expected_outcomes.push_back(schedule_command(cmd, item));
        requests_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_command(input int enq_pct, input bit narrow);
        logic [2:0]  cmd;
        logic [15:0] rem;
        logic [7:0]  pri;
        if ($urandom_range(0, 99) < enq_pct)
            cmd = CMD_ENQ;
        else if ($urandom_range(0, 99) == 0)
            cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        else
            cmd = 3'($urandom_range(CMD_POP, CMD_PEEK_SHORT));
        rem = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        pri = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
        if ($urandom_range(0, 19) == 0)
            rem = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 19) == 0)
            pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        send_request(cmd, 16'($urandom), rem, pri);
    endtask

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_outcome head;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outcomes.size() == 0) begin
                log_mismatch("result with no request outstanding");
            end else begin
                head = expected_outcomes.pop_front();
                results_checked++;
                if (o_status !== head.status || o_pid_out !== head.entry.pid ||
                    o_remaining_out !== head.entry.rem ||
                    o_priority_out !== head.entry.pri || o_occupancy !== head.occupancy)
                    log_mismatch($sformatf({"exp st %0d pid %h rem %h pri %h occ %0d, ",
                        "got st %0d pid %h rem %h pri %h occ %0d"},
                        head.status, head.entry.pid, head.entry.rem, head.entry.pri,
                        head.occupancy, o_status, o_pid_out, o_remaining_out,
                        o_priority_out, o_occupancy));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
                i_out_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic test_empty_queue();
        send_request(CMD_POP, 16'h0000, 16'h0000, 8'h00);
        send_request(CMD_PEEK_FRONT, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(CMD_REM_SHORT, 16'h0000, 16'h0000, 8'h00);
        send_request(CMD_REM_PRI, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(CMD_PEEK_SHORT, 16'h0000, 16'h0000, 8'h00);
    endtask

    task automatic test_unused_codes();
        send_request(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(CMD_SPARE_HI, 16'h1234, 16'h5678, 8'h9A);
    endtask

    task automatic test_fill_to_full();
        logic [15:0] pid;
        logic [15:0] rem;
        logic [7:0]  pri;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            pid = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom);
            rem = (i == 2 || i == 7) ? 16'h0000 : (i == 3) ? 16'hFFFF : 16'(100 + i % 3);
            pri = (i == 4 || i == 9) ? 8'h00 : (i == 5) ? 8'hFF : 8'(50 + i % 2);
            send_request(CMD_ENQ, pid, rem, pri);
        end
        send_request(CMD_ENQ, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(CMD_PEEK_SHORT, 16'h0000, 16'h0000, 8'h00);
    endtask

    task automatic test_random_mix();
        int enq_pct;
        bit narrow;
        for (int phase = 0; phase < 45; phase++) begin
            case ($urandom_range(0, 2))
                0: enq_pct = 80;
                1: enq_pct = 50;
                default: enq_pct = 20;
            endcase
            narrow = $urandom_range(0, 1);
            idling_on = $urandom_range(0, 3) != 0;
            repeat (30) random_command(enq_pct, narrow);
        end
        idling_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_request = LONG_HOLD;
        repeat (50) random_command(60, 1'b0);
        wait_drained();
        repeat (10) random_command(50, 1'b1);
    endtask

    task automatic test_unthrottled_tail();
        idling_on = 1'b0;
        for (int phase = 0; phase < 10; phase++)
            repeat (50) random_command((phase % 2) ? 70 : 30, phase[2]);
        wait_drained();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_cmd          <= CMD_ENQ;
        i_pid_in       <= 16'h0000;
        i_remaining_in <= 16'h0000;
        i_priority_in  <= 8'h00;
        idling_on       = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_unused_codes();
        test_fill_to_full();
        test_random_mix();
        test_output_backpressure();
        test_unthrottled_tail();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests and %0d checked results, peak occupancy %0d",
                 requests_sent, results_checked, peak_occupancy);
        $display("full-queue drops %0d, empty-queue reads %0d, mismatches %0d",
                 full_drops, empty_hits, mismatch_count);
        if (mismatch_count == 0 && expected_outcomes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
